@@ hdl/graph_store_bfs_dfs_engine_core_assert.svh @@
// ----------------------------------------------------------------------------
// graph_store_bfs_dfs_engine_core_assert.svh
// Assertion macros for the graph store engine.
// ----------------------------------------------------------------------------
`ifndef GRAPH_STORE_BFS_DFS_ENGINE_CORE_ASSERT_SVH
`define GRAPH_STORE_BFS_DFS_ENGINE_CORE_ASSERT_SVH

// same-cycle implication
`define GSBDE_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GSBDE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/gsbde_pkg.sv @@
// ----------------------------------------------------------------------------
// gsbde_pkg
// Opcodes, status codes and fixed field widths of the graph store engine.
// ----------------------------------------------------------------------------
`default_nettype none

package gsbde_pkg;

  localparam int OP_BITS  = 3;
  localparam int ST_BITS  = 3;
  localparam int CFG_BITS = 5;

  localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd0;
  localparam logic [OP_BITS-1:0] OP_ADD_V = 3'd1;
  localparam logic [OP_BITS-1:0] OP_DEL_V = 3'd2;
  localparam logic [OP_BITS-1:0] OP_ADD_E = 3'd3;
  localparam logic [OP_BITS-1:0] OP_DEL_E = 3'd4;
  localparam logic [OP_BITS-1:0] OP_DFS   = 3'd5;
  localparam logic [OP_BITS-1:0] OP_BFS   = 3'd6;

  localparam logic [ST_BITS-1:0] ST_OK        = 3'd0;
  localparam logic [ST_BITS-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_BITS-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [ST_BITS-1:0] ST_LIST_FULL = 3'd3;
  localparam logic [ST_BITS-1:0] ST_NONE      = 3'd4;

endpackage

`default_nettype wire

@@ hdl/graph_store_bfs_dfs_engine_core.sv @@
// ----------------------------------------------------------------------------
// graph_store_bfs_dfs_engine_core
// Directed graph store in labelled slots with ordered neighbor lists held in
// a synchronous-read memory; edits and depth/breadth-first walks.
// ----------------------------------------------------------------------------
//  channel  handshake          payload
//  item     item_valid/stall   opcode, first_label, second_label
//  result   result_valid/stall vertex_label, status, last_result
//  cfg      cfg_valid/ready    slots_in_use
//
//  Label lookup scans one slot per cycle for each endpoint; list entries
//  are read through the neighbor memory port, and vertex delete sweeps
//  all lists, compacting each. Depth-first scans slots for a root, then
//  reads the edges of the stack top; breadth-first reads the edges of each
//  dequeued vertex. Reset empties the graph, no pass. A walk runs one
//  result ahead of a stalled output, then holds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph_store_bfs_dfs_engine_core_assert.svh"

module graph_store_bfs_dfs_engine_core #(
  parameter int MAX_SLOTS  = 16,
  parameter int MAX_DEGREE = 16,
  parameter int LABEL_BITS = 15
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic [gsbde_pkg::OP_BITS-1:0]  opcode,
  input  wire logic [LABEL_BITS-1:0]          first_label,
  input  wire logic [LABEL_BITS-1:0]          second_label,
  output logic                                result_valid,
  input  wire logic                           result_stall,
  output logic [LABEL_BITS-1:0]               vertex_label,
  output logic [gsbde_pkg::ST_BITS-1:0]       status,
  output logic                                last_result,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [gsbde_pkg::CFG_BITS-1:0] slots_in_use
);
  import gsbde_pkg::*;

  localparam int SW    = $clog2(MAX_SLOTS);
  localparam int SCW   = $clog2(MAX_SLOTS + 1);
  localparam int PW    = $clog2(MAX_DEGREE);
  localparam int CW    = $clog2(MAX_DEGREE + 1);
  localparam int DEPTH = MAX_SLOTS * MAX_DEGREE;
  localparam int AW    = $clog2(DEPTH);
  localparam int CFG_RST = ((MAX_SLOTS % 32) == 0) ? 31 : (MAX_SLOTS % 32);
  localparam int ACT_RST = (CFG_RST > MAX_SLOTS) ? MAX_SLOTS : CFG_RST;

  typedef enum logic [4:0] {
    S_IDLE, S_FIND, S_DV_RD, S_DV_WR, S_DE_RD, S_DE_CHK, S_SH_RD, S_SH_WR,
    S_AE_WR, S_DF_ROOT, S_DF_TOP, S_DF_NB, S_BF_HEAD, S_BF_RD, S_BF_NB,
    S_EMIT, S_FLUSH
  } state_t;

  state_t                state;
  logic [OP_BITS-1:0]    op;
  logic                  phase;
  logic [LABEL_BITS-1:0] key;
  logic [LABEL_BITS-1:0] key_b;
  logic [SCW-1:0]        fi;
  logic [SW-1:0]         si;
  logic [SW-1:0]         di;
  logic [SW-1:0]         vi;
  logic [SW-1:0]         u;
  logic [SCW-1:0]        i;
  logic [CW-1:0]         p;
  logic [CW-1:0]         k;
  logic [SCW-1:0]        r;
  logic [SCW-1:0]        sp;
  logic [SCW-1:0]        head;
  logic [SCW-1:0]        tail;
  logic [SCW-1:0]        active;
  logic [CFG_BITS-1:0]   cfg_reg;
  logic [ST_BITS-1:0]    done_status;
  logic                  hold_valid;
  logic [LABEL_BITS-1:0] hold_label;

  logic [MAX_SLOTS-1:0]  occupied;
  logic [MAX_SLOTS-1:0]  visited;
  logic [CW-1:0]         count      [MAX_SLOTS];
  logic [LABEL_BITS-1:0] slot_label [MAX_SLOTS];
  logic [SW-1:0]         stk_slot   [MAX_SLOTS];
  logic [CW-1:0]         stk_pos    [MAX_SLOTS];
  logic [SW-1:0]         queue      [MAX_SLOTS];

  logic [SW-1:0]         nbr_mem [DEPTH];
  logic [SW-1:0]         mem_rdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [SW-1:0]         mem_wdata;

  logic [SW-1:0]         fi_i;
  logic [SW-1:0]         i_i;
  logic [SW-1:0]         top_idx;
  logic [SW-1:0]         top_slot;
  logic [CW-1:0]         top_pos;
  logic [SW-1:0]         lbl_raddr;
  logic [LABEL_BITS-1:0] lbl_rdata;
  logic [SW-1:0]         cnt_raddr;
  logic [CW-1:0]         cnt_rdata;
  logic [CW-1:0]         p1;
  logic                  free_found;
  logic [SW-1:0]         free_slot;
  logic                  fnd;
  logic                  match;
  logic                  usable_w;
  logic                  usable_r;
  logic                  out_free;
  logic                  can_push;
  logic [SW-1:0]         found_slot;
  logic [SCW-1:0]        active_next;

  function automatic logic [AW-1:0] naddr(input logic [SW-1:0] s, input logic [CW-1:0] q);
    return AW'(s) * AW'(MAX_DEGREE) + AW'(q[PW-1:0]);
  endfunction

  assign item_stall = (state != S_IDLE);
  assign cfg_ready  = 1'b1;

  assign fi_i      = fi[SW-1:0];
  assign i_i       = i[SW-1:0];
  assign top_idx   = SW'(sp - SCW'(1));
  assign top_slot  = stk_slot[top_idx];
  assign top_pos   = stk_pos[top_idx];
  assign lbl_rdata = slot_label[lbl_raddr];
  assign cnt_rdata = count[cnt_raddr];
  assign p1        = p + CW'(1);
  assign fnd       = (fi != active);
  assign match     = occupied[fi_i] && (lbl_rdata == key);
  assign usable_w  = (SCW'(mem_rdata) < active) && occupied[mem_rdata] && !visited[mem_rdata];
  assign usable_r  = occupied[r[SW-1:0]] && !visited[r[SW-1:0]];
  assign out_free  = !result_valid || !result_stall;
  assign can_push  = !hold_valid || out_free;
  assign found_slot = fnd ? fi_i : free_slot;

  always_comb begin
    if (int'(cfg_reg) > MAX_SLOTS) begin
      active_next = SCW'(MAX_SLOTS);
    end else if (cfg_reg == '0) begin
      active_next = SCW'(1);
    end else begin
      active_next = SCW'(cfg_reg);
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int n = MAX_SLOTS - 1; n >= 0; n--) begin
      if ((SCW'(n) < active) && !occupied[n]) begin
        free_found = 1'b1;
        free_slot  = SW'(n);
      end
    end
  end

  always_comb begin
    unique case (state)
      S_DF_TOP: begin
        lbl_raddr = top_slot;
        cnt_raddr = top_slot;
      end
      S_BF_RD: begin
        lbl_raddr = u;
        cnt_raddr = u;
      end
      S_DV_RD: begin
        lbl_raddr = fi_i;
        cnt_raddr = i_i;
      end
      default: begin
        lbl_raddr = fi_i;
        cnt_raddr = si;
      end
    endcase
  end

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = mem_rdata;
    unique case (state)
      S_DV_RD: begin
        mem_re    = (i != SCW'(MAX_SLOTS)) && (p < cnt_rdata);
        mem_raddr = naddr(i_i, p);
      end
      S_DV_WR: begin
        mem_we    = (mem_rdata != vi);
        mem_waddr = naddr(i_i, k);
      end
      S_DE_RD: begin
        mem_re    = (p < cnt_rdata);
        mem_raddr = naddr(si, p);
      end
      S_SH_RD: begin
        mem_re    = (p1 < cnt_rdata);
        mem_raddr = naddr(si, p1);
      end
      S_SH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = naddr(si, p);
      end
      S_AE_WR: begin
        mem_we    = (cnt_rdata < CW'(MAX_DEGREE));
        mem_waddr = naddr(si, cnt_rdata);
        mem_wdata = di;
      end
      S_DF_TOP: begin
        mem_re    = (top_pos < cnt_rdata);
        mem_raddr = naddr(top_slot, top_pos);
      end
      S_BF_RD: begin
        mem_re    = (p < cnt_rdata);
        mem_raddr = naddr(u, p);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      nbr_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= nbr_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
      hold_valid   <= 1'b0;
      occupied     <= '0;
      active       <= SCW'(ACT_RST);
      cfg_reg      <= CFG_BITS'(CFG_RST);
      sp           <= '0;
      head         <= '0;
      tail         <= '0;
      for (int n = 0; n < MAX_SLOTS; n++) begin
        count[n] <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_reg <= slots_in_use;
      end
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (item_valid) begin
            op    <= opcode;
            key   <= first_label;
            key_b <= second_label;
            phase <= 1'b0;
            fi    <= '0;
            unique case (opcode)
              OP_CLEAR: begin
                active   <= active_next;
                occupied <= '0;
                for (int n = 0; n < MAX_SLOTS; n++) begin
                  count[n] <= '0;
                end
                done_status <= ST_OK;
                state       <= S_EMIT;
              end
              OP_ADD_V: begin
                if (free_found) begin
                  occupied[free_slot]   <= 1'b1;
                  slot_label[free_slot] <= first_label;
                  count[free_slot]      <= '0;
                end
                done_status <= free_found ? ST_OK : ST_FULL;
                state       <= S_EMIT;
              end
              OP_DEL_V, OP_ADD_E, OP_DEL_E: begin
                state <= S_FIND;
              end
              OP_DFS: begin
                visited    <= '0;
                hold_valid <= 1'b0;
                r          <= '0;
                state      <= S_DF_ROOT;
              end
              OP_BFS: begin
                hold_valid <= 1'b0;
                if (occupied[0]) begin
                  visited    <= MAX_SLOTS'(1);
                  queue[0]   <= '0;
                  head       <= '0;
                  tail       <= SCW'(1);
                  state      <= S_BF_HEAD;
                end else begin
                  visited <= '0;
                  state   <= S_FLUSH;
                end
              end
              default: begin
                done_status <= ST_OK;
                state       <= S_EMIT;
              end
            endcase
          end
        end

        S_FIND: begin
          if (!fnd || match) begin
            unique case (op)
              OP_DEL_V: begin
                if (!fnd) begin
                  done_status <= ST_NOT_FOUND;
                  state       <= S_EMIT;
                end else begin
                  vi    <= fi_i;
                  i     <= '0;
                  p     <= '0;
                  k     <= '0;
                  state <= S_DV_RD;
                end
              end
              OP_ADD_E: begin
                if (fnd || free_found) begin
                  if (!fnd) begin
                    occupied[free_slot]   <= 1'b1;
                    slot_label[free_slot] <= key;
                    count[free_slot]      <= '0;
                  end
                  if (!phase) begin
                    si    <= found_slot;
                    phase <= 1'b1;
                    key   <= key_b;
                    fi    <= '0;
                  end else begin
                    di    <= found_slot;
                    state <= S_AE_WR;
                  end
                end else begin
                  done_status <= ST_FULL;
                  state       <= S_EMIT;
                end
              end
              OP_DEL_E: begin
                if (!fnd) begin
                  done_status <= ST_NOT_FOUND;
                  state       <= S_EMIT;
                end else if (!phase) begin
                  si    <= fi_i;
                  phase <= 1'b1;
                  key   <= key_b;
                  fi    <= '0;
                end else begin
                  di    <= fi_i;
                  p     <= '0;
                  state <= S_DE_RD;
                end
              end
              default: begin
                done_status <= ST_OK;
                state       <= S_EMIT;
              end
            endcase
          end else begin
            fi <= fi + SCW'(1);
          end
        end

        S_DV_RD: begin
          if (i == SCW'(MAX_SLOTS)) begin
            occupied[vi] <= 1'b0;
            count[vi]    <= '0;
            done_status  <= ST_OK;
            state        <= S_EMIT;
          end else if (p < cnt_rdata) begin
            p     <= p + CW'(1);
            state <= S_DV_WR;
          end else begin
            count[i_i] <= k;
            i          <= i + SCW'(1);
            p          <= '0;
            k          <= '0;
          end
        end

        S_DV_WR: begin
          if (mem_rdata != vi) begin
            k <= k + CW'(1);
          end
          state <= S_DV_RD;
        end

        S_DE_RD: begin
          if (p < cnt_rdata) begin
            state <= S_DE_CHK;
          end else begin
            done_status <= ST_NOT_FOUND;
            state       <= S_EMIT;
          end
        end

        S_DE_CHK: begin
          if (mem_rdata == di) begin
            state <= S_SH_RD;
          end else begin
            p     <= p1;
            state <= S_DE_RD;
          end
        end

        S_SH_RD: begin
          if (p1 < cnt_rdata) begin
            state <= S_SH_WR;
          end else begin
            count[si]   <= cnt_rdata - CW'(1);
            done_status <= ST_OK;
            state       <= S_EMIT;
          end
        end

        S_SH_WR: begin
          p     <= p1;
          state <= S_SH_RD;
        end

        S_AE_WR: begin
          if (cnt_rdata < CW'(MAX_DEGREE)) begin
            count[si]   <= cnt_rdata + CW'(1);
            done_status <= ST_OK;
          end else begin
            done_status <= ST_LIST_FULL;
          end
          state <= S_EMIT;
        end

        S_DF_ROOT: begin
          if (r == active) begin
            state <= S_FLUSH;
          end else if (usable_r) begin
            visited[r[SW-1:0]] <= 1'b1;
            stk_slot[0]        <= r[SW-1:0];
            stk_pos[0]         <= '0;
            sp                 <= SCW'(1);
            state              <= S_DF_TOP;
          end else begin
            r <= r + SCW'(1);
          end
        end

        S_DF_TOP: begin
          if (top_pos < cnt_rdata) begin
            stk_pos[top_idx] <= top_pos + CW'(1);
            state            <= S_DF_NB;
          end else if (can_push) begin
            if (hold_valid) begin
              result_valid <= 1'b1;
              vertex_label <= hold_label;
              status       <= ST_OK;
              last_result  <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_label <= lbl_rdata;
            sp         <= sp - SCW'(1);
            if (sp == SCW'(1)) begin
              r     <= r + SCW'(1);
              state <= S_DF_ROOT;
            end
          end
        end

        S_DF_NB: begin
          if (usable_w && (sp < SCW'(MAX_SLOTS))) begin
            visited[mem_rdata]  <= 1'b1;
            stk_slot[SW'(sp)]   <= mem_rdata;
            stk_pos[SW'(sp)]    <= '0;
            sp                  <= sp + SCW'(1);
          end
          state <= S_DF_TOP;
        end

        S_BF_HEAD: begin
          if (head == tail) begin
            state <= S_FLUSH;
          end else begin
            u     <= queue[SW'(head)];
            head  <= head + SCW'(1);
            p     <= '0;
            state <= S_BF_RD;
          end
        end

        S_BF_RD: begin
          if (p < cnt_rdata) begin
            p     <= p1;
            state <= S_BF_NB;
          end else if (can_push) begin
            if (hold_valid) begin
              result_valid <= 1'b1;
              vertex_label <= hold_label;
              status       <= ST_OK;
              last_result  <= 1'b0;
            end
            hold_valid <= 1'b1;
            hold_label <= lbl_rdata;
            state      <= S_BF_HEAD;
          end
        end

        S_BF_NB: begin
          if (usable_w && (tail < SCW'(MAX_SLOTS))) begin
            visited[mem_rdata] <= 1'b1;
            queue[SW'(tail)]   <= mem_rdata;
            tail               <= tail + SCW'(1);
          end
          state <= S_BF_RD;
        end

        S_FLUSH: begin
          if (out_free) begin
            result_valid <= 1'b1;
            vertex_label <= hold_valid ? hold_label : '0;
            status       <= hold_valid ? ST_OK : ST_NONE;
            last_result  <= 1'b1;
            hold_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end

        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            vertex_label <= '0;
            status       <= done_status;
            last_result  <= 1'b1;
            state        <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `GSBDE_ASSERT(a_stack_live, state == S_DF_TOP, sp != '0, "stack empty at top read")
  `GSBDE_ASSERT(a_queue_order, state == S_BF_HEAD,
    (head <= tail) && (tail <= SCW'(MAX_SLOTS)), "queue pointers out of order")
  `GSBDE_ASSERT_NEXT(a_hold_drain, (state == S_FLUSH) && out_free,
    !hold_valid && (state == S_IDLE), "held result not drained")

endmodule

`default_nettype wire
